// ----- rtl/pip_pkg.sv -----
// Shared constants, types and control struct of the point-in-polygon block.
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;
  localparam int IDX_BITS     = $clog2(MAX_VERTICES);
  localparam int CNT_BITS     = 7;
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS    = 2 * DIFF_BITS;
  localparam int VERT_BITS    = 2 * COORD_BITS;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TEST  = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic [IDX_BITS-1:0]          idx_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;

  // Control from the sequencer to the edge datapath.
  typedef struct packed {
    logic load_query;
    logic load_prev;
    logic load_edge;
    logic mul_left;
    logic mul_right;
    logic compare;
  } pip_ctl_t;

endpackage

// ----- rtl/pip_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/pip_edge.sv -----
// Edge datapath: differences, one shared multiplier, crossing compare and parity.
module pip_edge
  import pip_pkg::*;
(
  input  logic                 clk,
  input  pip_ctl_t             ctl,
  input  coord_t               coord_x,
  input  coord_t               coord_y,
  input  logic [VERT_BITS-1:0] vert_data,
  output logic                 straddle,
  output logic                 parity
);

  coord_t px, py, qx, qy;
  coord_t cx, cy;
  diff_t  dx, dy;
  diff_t  a_r, b_r, s_r, dyabs_r;
  prod_t  lprod, rprod, prod;
  diff_t  op_a, op_b;

  assign cx = coord_t'(vert_data[VERT_BITS-1:COORD_BITS]);
  assign cy = coord_t'(vert_data[COORD_BITS-1:0]);
  assign dx = DIFF_BITS'(qx) - DIFF_BITS'(cx);
  assign dy = DIFF_BITS'(qy) - DIFF_BITS'(cy);

  // The multiplier serves the left product first, then the right one.
  assign op_a = ctl.mul_left ? a_r : s_r;
  assign op_b = ctl.mul_left ? dyabs_r : b_r;
  assign prod = op_a * op_b;

  always_ff @(posedge clk) begin
    if (ctl.load_query) begin
      px     <= coord_x;
      py     <= coord_y;
      parity <= 1'b0;
    end
    if (ctl.load_prev || ctl.load_edge) begin
      qx <= cx;
      qy <= cy;
    end
    if (ctl.load_edge) begin
      a_r      <= DIFF_BITS'(px) - DIFF_BITS'(cx);
      b_r      <= DIFF_BITS'(py) - DIFF_BITS'(cy);
      dyabs_r  <= (dy < 0) ? -dy : dy;
      s_r      <= (dy > 0) ? dx : -dx;
      straddle <= (cy > py) != (qy > py);
    end
    if (ctl.mul_left) begin
      lprod <= prod;
    end
    if (ctl.mul_right) begin
      rprod <= prod;
    end
    if (ctl.compare && (lprod < rprod)) begin
      parity <= ~parity;
    end
  end

endmodule

// ----- rtl/point_in_polygon_test_top.sv -----
// Top level of the point-in-polygon block: sequencer, vertex store and edge datapath.
//
// Items arrive on the item channel (item_valid / item_stall) with fields func,
// vertex_index, coord_x and coord_y. A write item (func = 0) stores one vertex
// and gives no result. A test item (func = 1) walks every active edge of the
// polygon and returns one bit, inside_res, on the result channel
// (res_valid / res_stall).
// The vertex count is written through cfg_valid / cfg_ready / cfg_data, which
// is always ready; values above the store depth use the whole store.
// A test first reads and loads the closing vertex of the polygon; then each
// edge costs a store read and a load, and an edge that straddles the query
// line adds two passes through the single multiplier and a compare. A test
// with no vertices skips the store and goes straight to its result.
// item_stall is high while a test is in progress. A finished result sits in
// the output register; a following item is taken while it waits, but a new
// result is held back until the receiver takes the old one.
// Reset (rst, synchronous) clears the vertex count and the sequencer; the
// vertex store is not cleared and must be written before it is tested.
module point_in_polygon_test_top
  import pip_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        func,
  input  logic [5:0]  vertex_index,
  input  coord_t      coord_x,
  input  coord_t      coord_y,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        inside_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cnt_t        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_PREV, S_LD_PREV, S_READ, S_LOAD, S_MUL_L, S_MUL_R, S_CMP, S_DONE
  } state_t;

  state_t               state;
  cnt_t                 vertex_count;
  cnt_t                 n_eff, n_m1;
  idx_t                 last_idx;
  idx_t                 k;
  idx_t                 rd_addr;
  logic                 item_take;
  logic                 wr_en;
  logic                 res_load;
  logic [VERT_BITS-1:0] rd_data;
  pip_ctl_t             ctl;
  logic                 straddle;
  logic                 parity;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign wr_en      = item_take && (func == FUNC_WRITE) &&
                      (32'(vertex_index) < MAX_VERTICES);
  assign res_load   = (state == S_DONE) && (!res_valid || !res_stall);

  assign n_eff    = (vertex_count > CNT_BITS'(MAX_VERTICES)) ? CNT_BITS'(MAX_VERTICES)
                                                             : vertex_count;
  assign n_m1     = n_eff - CNT_BITS'(1);
  assign last_idx = n_m1[IDX_BITS-1:0];
  assign rd_addr  = (state == S_RD_PREV) ? last_idx : k;

  always_comb begin
    ctl            = '0;
    ctl.load_query = item_take && (func == FUNC_TEST);
    ctl.load_prev  = (state == S_LD_PREV);
    ctl.load_edge  = (state == S_LOAD);
    ctl.mul_left   = (state == S_MUL_L) && straddle;
    ctl.mul_right  = (state == S_MUL_R);
    ctl.compare    = (state == S_CMP);
  end

  pip_ram #(
    .WIDTH (VERT_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk     (clk),
    .we      (wr_en),
    .wr_addr (vertex_index[IDX_BITS-1:0]),
    .wr_data ({coord_x, coord_y}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pip_edge u_edge (
    .clk       (clk),
    .ctl       (ctl),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .vert_data (rd_data),
    .straddle  (straddle),
    .parity    (parity)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= '0;
      res_valid    <= 1'b0;
      k            <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if (res_load) begin
        res_valid  <= 1'b1;
        inside_res <= parity;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_take && (func == FUNC_TEST)) begin
            k     <= '0;
            state <= (n_eff == '0) ? S_DONE : S_RD_PREV;
          end
        end
        S_RD_PREV: state <= S_LD_PREV;
        S_LD_PREV: state <= S_READ;
        S_READ:    state <= S_LOAD;
        S_LOAD:    state <= S_MUL_L;
        S_MUL_L: begin
          // An edge that does not cross the query line is skipped here.
          if (straddle) begin
            state <= S_MUL_R;
          end else if (k == last_idx) begin
            state <= S_DONE;
          end else begin
            k     <= k + 1'b1;
            state <= S_READ;
          end
        end
        S_MUL_R:   state <= S_CMP;
        S_CMP: begin
          if (k == last_idx) begin
            state <= S_DONE;
          end else begin
            k     <= k + 1'b1;
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- test/point_in_polygon_test_top_test.sv -----
// Self-checking testbench of the point-in-polygon block with a built-in parity predictor.
`timescale 1ns / 100ps

module point_in_polygon_test_top_test
  import pip_pkg::*;
();

  localparam int SETTLE_CYCLES = 5 * MAX_VERTICES + 8;
  localparam int STALL_LIMIT   = 4000;
  localparam int RAND_PHASES   = 24;

  typedef struct {
    logic   fn;
    idx_t   slot;
    coord_t x;
    coord_t y;
  } poly_item_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   item_valid = 1'b0;
  logic   item_stall;
  logic   func = FUNC_WRITE;
  idx_t   vertex_index = '0;
  coord_t coord_x = '0;
  coord_t coord_y = '0;
  logic   res_valid;
  logic   res_stall = 1'b0;
  logic   inside_res;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  cnt_t   cfg_data = '0;

  // Predictor copy of the polygon and of the vertex count.
  coord_t poly_x [MAX_VERTICES];
  coord_t poly_y [MAX_VERTICES];
  cnt_t   poly_count = '0;

  // Stimulus-side copy of the vertices, used to aim queries at them.
  coord_t stim_x [MAX_VERTICES];
  coord_t stim_y [MAX_VERTICES];

  poly_item_t pending_items[$];
  logic       expected_inside[$];
  logic       want_inside;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         error_count = 0;
  int         quiet_cycles = 0;

  point_in_polygon_test_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .vertex_index (vertex_index),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .inside_res   (inside_res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // Even-odd crossing count over every edge, compared by exact cross-multiplication.
  function automatic logic point_inside(coord_t px, coord_t py);
    int     n;
    int     j;
    logic   parity;
    coord_t cx, cy, qx, qy;
    diff_t  dx, dy, sdx, ady, dpx, dpy;
    prod_t  lhs, rhs;
    n = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
    parity = 1'b0;
    for (int i = 0; i < n; i++) begin
      j = (i == 0) ? n - 1 : i - 1;
      cx = poly_x[i];
      cy = poly_y[i];
      qx = poly_x[j];
      qy = poly_y[j];
      if ((cy > py) != (qy > py)) begin
        dx  = qx - cx;
        dy  = qy - cy;
        sdx = (dy > 0) ? dx : -dx;
        ady = (dy > 0) ? dy : -dy;
        dpx = px - cx;
        dpy = py - cy;
        lhs = dpx * ady;
        rhs = sdx * dpy;
        if (lhs < rhs) parity = ~parity;
      end
    end
    return parity;
  endfunction

  // Item driver: presents queued items and updates the predictor on acceptance.
  always @(posedge clk) begin : item_driver
    poly_item_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        if (func == FUNC_WRITE) begin
          poly_x[vertex_index] = coord_x;
          poly_y[vertex_index] = coord_y;
        end else begin
          expected_inside = {expected_inside, point_inside(coord_x, coord_y)};
        end
      end
      if (!item_valid || !item_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          item_valid   <= 1'b1;
          func         <= nxt.fn;
          vertex_index <= nxt.slot;
          coord_x      <= nxt.x;
          coord_y      <= nxt.y;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin : result_monitor
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_inside.size() == 0) begin
          $error("inside_res: expected no result, actual %0b", inside_res);
          error_count++;
        end else begin
          want_inside = expected_inside.pop_front();
          if (inside_res !== want_inside) begin
            $error("inside_res: expected %0b, actual %0b", want_inside, inside_res);
            error_count++;
          end
        end
      end
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (item_valid && !item_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("point_in_polygon_test_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_write(input int slot, input coord_t x, input coord_t y);
    poly_item_t it;
    it.fn   = FUNC_WRITE;
    it.slot = idx_t'(slot);
    it.x    = x;
    it.y    = y;
    stim_x[slot] = x;
    stim_y[slot] = y;
    pending_items = {pending_items, it};
  endtask

  task automatic push_test(input coord_t x, input coord_t y);
    poly_item_t it;
    it.fn   = FUNC_TEST;
    it.slot = idx_t'($urandom);
    it.x    = x;
    it.y    = y;
    pending_items = {pending_items, it};
  endtask

  // Waits until every item is taken and every result is back, then lets a
  // last write item finish.
  task automatic drain_items();
    while (pending_items.size() > 0 || item_valid || expected_inside.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input cnt_t value);
    drain_items();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    poly_count = value;
  endtask

  function automatic coord_t pick_coord(input int span);
    if (span >= 32768) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(2 * span)) - span);
  endfunction

  // One setting of the vertex count: a fresh polygon, then a mix of queries
  // and stray vertex writes.
  task automatic run_random_phase(input cnt_t count);
    int n;
    int span;
    int pick;
    int v;
    n = (count > MAX_VERTICES) ? MAX_VERTICES : int'(count);
    case ($urandom_range(3))
      0:       span = 16;
      1:       span = 1000;
      default: span = 32768;
    endcase
    set_vertex_count(count);
    for (int s = 0; s < n; s++) begin
      // Some edges are made horizontal by repeating the previous y.
      if (s > 0 && $urandom_range(3) == 0)
        push_write(s, pick_coord(span), stim_y[s-1]);
      else
        push_write(s, pick_coord(span), pick_coord(span));
    end
    repeat (30) begin
      pick = $urandom_range(9);
      v = (n > 0) ? $urandom_range(n - 1) : 0;
      if (pick < 2)
        push_write($urandom_range(MAX_VERTICES - 1), pick_coord(span), pick_coord(span));
      else if (pick < 6 || n == 0)
        push_test(pick_coord(span), pick_coord(span));
      else if (pick < 8)
        push_test(stim_x[v], stim_y[v]);
      else
        push_test(pick_coord(span), stim_y[v]);
    end
  endtask

  initial begin : stimulus
    cnt_t large_counts [4];
    cnt_t cnt;
    large_counts = '{7'd64, 7'd127, 7'd65, 7'd100};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 19;
    recv_idle_pct = 74;

    // Empty polygon, then a full-range square and the top slot.
    set_vertex_count(7'd0);
    push_test(16'sd0, 16'sd0);
    push_test(-16'sd32768, 16'sd32767);
    push_write(0, -16'sd32768, -16'sd32768);
    push_write(1, 16'sd32767, -16'sd32768);
    push_write(2, 16'sd32767, 16'sd32767);
    push_write(3, -16'sd32768, 16'sd32767);
    push_write(MAX_VERTICES - 1, -16'sd1, -16'sd1);

    set_vertex_count(7'd4);
    push_test(16'sd0, 16'sd0);
    push_test(-16'sd32768, -16'sd32768);
    push_test(16'sd32767, 16'sd0);
    push_test(-16'sd32768, 16'sd0);
    push_test(16'sd0, 16'sd32767);
    push_test(16'sd0, -16'sd32768);
    push_test(-16'sd1, -16'sd1);

    // A single vertex never straddles; two vertices form two opposite edges.
    set_vertex_count(7'd1);
    push_test(-16'sd32768, -16'sd32768);
    push_write(1, 16'sd32767, 16'sd32767);
    set_vertex_count(7'd2);
    push_test(16'sd0, 16'sd0);
    push_test(-16'sd100, 16'sd0);
    push_test(16'sd100, 16'sd0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < RAND_PHASES / 3) begin
        send_idle_pct = 19;
        recv_idle_pct = 74;
      end else if (p < 2 * RAND_PHASES / 3) begin
        send_idle_pct = 74;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      cnt = (p % 6 == 3) ? large_counts[p / 6] : cnt_t'($urandom_range(12));
      run_random_phase(cnt);
    end

    drain_items();
    if (error_count == 0)
      $display("point_in_polygon_test_top test passed");
    else
      $display("point_in_polygon_test_top test failed");
    $finish;
  end

endmodule
